### rtl/core/mtbc_pkg.sv
package mtbc_pkg;

  localparam int unsigned StackDepthDefault = 16;
  localparam int unsigned MaxTagLenDefault  = 16;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_STRAY_GT     = 4'd1;
  localparam logic [3:0] ERR_EMPTY_NAME   = 4'd2;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd3;
  localparam logic [3:0] ERR_CLOSE_EMPTY  = 4'd4;
  localparam logic [3:0] ERR_MISMATCH     = 4'd5;
  localparam logic [3:0] ERR_UNCLOSED     = 4'd6;
  localparam logic [3:0] ERR_NO_TAGS      = 4'd7;
  localparam logic [3:0] ERR_TOO_LONG     = 4'd8;
  localparam logic [3:0] ERR_OVERFLOW     = 4'd9;

  typedef enum logic [2:0] {
    KIND_SPACE,
    KIND_LT,
    KIND_GT,
    KIND_SLASH,
    KIND_OTHER
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_in;
    logic       is_last;
  } item_t;

endpackage

### rtl/core/mtbc_in_if.sv
interface mtbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink (input valid, input char_in, input is_last, output ready);
endinterface

### rtl/core/mtbc_out_if.sv
interface mtbc_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [3:0] error_code;

  modport source (output valid, output valid_res, output error_code, input ready);
  modport sink (input valid, input valid_res, input error_code, output ready);
endinterface

### rtl/core/mtbc_front.sv
module mtbc_front
  import mtbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  [7:0] char_in_i,
  input  logic  is_last_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_pop_i
);

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  kind_e      kind;
  logic       push;
  logic       accept;

  always_comb begin
    if (char_in_i == CHAR_SPACE || (char_in_i >= CHAR_TAB && char_in_i <= CHAR_CR)) begin
      kind = KIND_SPACE;
    end else if (char_in_i == CHAR_LT) begin
      kind = KIND_LT;
    end else if (char_in_i == CHAR_GT) begin
      kind = KIND_GT;
    end else if (char_in_i == CHAR_SLASH) begin
      kind = KIND_SLASH;
    end else begin
      kind = KIND_OTHER;
    end
  end

  // Whitespace only matters when it closes the string.
  assign in_ready_o   = (count_q != 2'd2);
  assign accept       = in_valid_i && in_ready_o;
  assign push         = accept && (kind != KIND_SPACE || is_last_i);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{kind: kind, char_in: char_in_i, is_last: is_last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(item_pop_i);
    end
  end

endmodule

### rtl/core/mtbc_back.sv
module mtbc_back
  import mtbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned MAX_TAG_LEN = MaxTagLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [3:0] error_code_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TW  = $clog2(STACK_DEPTH);
  localparam int unsigned PW  = $clog2(MAX_TAG_LEN + 1);
  localparam int unsigned BA  = $clog2(STACK_DEPTH * MAX_TAG_LEN);

  typedef enum logic [1:0] {
    MODE_OUT,
    MODE_OPEN,
    MODE_NAME
  } mode_e;

  mode_e          mode_q, mode_d;
  logic           closing_q, closing_d;
  logic [3:0]     err_q, err_d;
  logic           seen_q, seen_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic           mm_q, mm_d;
  logic           out_valid_q, out_valid_d;
  logic           valid_res_q, valid_res_d;
  logic [3:0]     code_q, code_d;

  logic [7:0]     byte_mem [STACK_DEPTH * MAX_TAG_LEN];
  logic [PW-1:0]  len_mem [STACK_DEPTH];
  logic [7:0]     byte_rd_q;
  logic [PW-1:0]  len_rd_q;

  logic           byte_we, len_we;
  logic [BA-1:0]  byte_wa, byte_ra;
  logic [SPW-1:0] top_d;
  logic [PW-1:0]  pos_rd;
  logic           go;
  logic [3:0]     code;

  // A result can only be taken when the output register is free or being drained.
  assign go         = item_valid_i && !(item_i.is_last && out_valid_q && !out_ready_i);
  assign item_pop_o = go;

  always_comb begin
    mode_d      = mode_q;
    closing_d   = closing_q;
    err_d       = err_q;
    seen_d      = seen_q;
    sp_d        = sp_q;
    pos_d       = pos_q;
    mm_d        = mm_q;
    out_valid_d = out_valid_q && !out_ready_i;
    valid_res_d = valid_res_q;
    code_d      = code_q;
    byte_we     = 1'b0;
    len_we      = 1'b0;
    code        = ERR_NONE;

    if (go && err_q == ERR_NONE && item_i.kind != KIND_SPACE) begin
      unique case (mode_q)
        MODE_OUT: begin
          if (item_i.kind == KIND_LT) begin
            mode_d    = MODE_OPEN;
            closing_d = 1'b0;
            pos_d     = '0;
            mm_d      = 1'b0;
          end else if (item_i.kind == KIND_GT) begin
            err_d = ERR_STRAY_GT;
          end
        end
        MODE_OPEN, MODE_NAME: begin
          mode_d = MODE_NAME;
          if (mode_q == MODE_OPEN && item_i.kind == KIND_SLASH) begin
            closing_d = 1'b1;
          end else if (item_i.kind == KIND_GT) begin
            mode_d = MODE_OUT;
            if (pos_q == '0) begin
              err_d = ERR_EMPTY_NAME;
            end else if (closing_q) begin
              if (sp_q == '0) begin
                err_d = ERR_CLOSE_EMPTY;
              end else if (mm_q || pos_q != len_rd_q) begin
                err_d = ERR_MISMATCH;
              end else begin
                sp_d = sp_q - SPW'(1);
              end
            end else if (sp_q >= SPW'(STACK_DEPTH)) begin
              err_d = ERR_OVERFLOW;
            end else begin
              len_we = 1'b1;
              sp_d   = sp_q + SPW'(1);
              seen_d = 1'b1;
            end
          end else if (pos_q >= PW'(MAX_TAG_LEN)) begin
            err_d = ERR_TOO_LONG;
          end else begin
            if (closing_q) begin
              if (sp_q == '0 || pos_q >= len_rd_q || byte_rd_q != item_i.char_in) begin
                mm_d = 1'b1;
              end
            end else if (sp_q < SPW'(STACK_DEPTH)) begin
              byte_we = 1'b1;
            end
            pos_d = pos_q + PW'(1);
          end
        end
        default: begin
          mode_d = MODE_OUT;
        end
      endcase
    end

    if (go && item_i.is_last) begin
      if (err_d != ERR_NONE) begin
        code = err_d;
      end else if (mode_d != MODE_OUT) begin
        code = ERR_UNTERMINATED;
      end else if (sp_d != '0) begin
        code = ERR_UNCLOSED;
      end else if (!seen_d) begin
        code = ERR_NO_TAGS;
      end
      out_valid_d = 1'b1;
      valid_res_d = (code == ERR_NONE);
      code_d      = code;
      mode_d      = MODE_OUT;
      closing_d   = 1'b0;
      err_d       = ERR_NONE;
      seen_d      = 1'b0;
      sp_d        = '0;
      pos_d       = '0;
      mm_d        = 1'b0;
    end
  end

  // Reads are issued for the next state, so the top entry is ready in the cycle after.
  assign top_d   = sp_d - SPW'(1);
  assign pos_rd  = (pos_d >= PW'(MAX_TAG_LEN)) ? '0 : pos_d;
  assign byte_ra = BA'(top_d[TW-1:0]) * BA'(MAX_TAG_LEN) + BA'(pos_rd);
  assign byte_wa = BA'(sp_q[TW-1:0]) * BA'(MAX_TAG_LEN) + BA'(pos_q);

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_wa] <= item_i.char_in;
    end
    if (len_we) begin
      len_mem[sp_q[TW-1:0]] <= pos_q;
    end
    byte_rd_q <= byte_mem[byte_ra];
    len_rd_q  <= len_mem[top_d[TW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OUT;
      closing_q   <= 1'b0;
      err_q       <= ERR_NONE;
      seen_q      <= 1'b0;
      sp_q        <= '0;
      pos_q       <= '0;
      mm_q        <= 1'b0;
      out_valid_q <= 1'b0;
      valid_res_q <= 1'b0;
      code_q      <= ERR_NONE;
    end else begin
      mode_q      <= mode_d;
      closing_q   <= closing_d;
      err_q       <= err_d;
      seen_q      <= seen_d;
      sp_q        <= sp_d;
      pos_q       <= pos_d;
      mm_q        <= mm_d;
      out_valid_q <= out_valid_d;
      valid_res_q <= valid_res_d;
      code_q      <= code_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = valid_res_q;
  assign error_code_o = code_q;

endmodule

### rtl/core/markup_tag_balance_checker_core.sv
// Channel   Dir  Payload               Transfer
// byte_i    in   char_in, is_last      valid && ready
// result_o  out  valid_res, error_code valid && ready
//
// One byte is taken every cycle while the two-entry queue has room.
// A byte is carried out by the back end when it leaves the queue, which a stalled result can hold
// back for a final byte; a result is loaded into the output register as that final byte is carried out.
// Reset clears the scan state and both handshakes; the stack memories need no clearing.
// A stalled result only holds back the next final byte, not the bytes before it.
module markup_tag_balance_checker_core
  import mtbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned MAX_TAG_LEN = MaxTagLenDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  mtbc_in_if.sink    byte_i,
  mtbc_out_if.source result_o
);

  logic  item_valid;
  logic  item_pop;
  item_t item;

  mtbc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i   (byte_i.valid),
    .in_ready_o   (byte_i.ready),
    .char_in_i    (byte_i.char_in),
    .is_last_i    (byte_i.is_last),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  mtbc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_TAG_LEN (MAX_TAG_LEN)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .valid_res_o  (result_o.valid_res),
    .error_code_o (result_o.error_code)
  );

endmodule

### rtl/core/mtbc_checker.sv
module mtbc_checker
  import mtbc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       valid_res_i,
  input logic [3:0] error_code_i
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("Result shown during reset.");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> error_code_i <= ERR_OVERFLOW)
    else $error("Error code out of range.");

  a_res_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> valid_res_i == (error_code_i == ERR_NONE))
    else $error("Validity flag disagrees with the error code.");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result withdrawn before its transfer.");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(valid_res_i) && $stable(error_code_i))
    else $error("Result changed while stalled.");

endmodule

bind markup_tag_balance_checker_core mtbc_checker u_mtbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .valid_res_i  (result_o.valid_res),
  .error_code_i (result_o.error_code)
);
